// ----- sv/axis_angle_vertex_revolver_defines.svh -----
// Assertion macros for the revolver RTL.
`ifndef AXIS_ANGLE_VERTEX_REVOLVER_DEFINES_SVH
`define AXIS_ANGLE_VERTEX_REVOLVER_DEFINES_SVH

// same-cycle implication
`define AAVR_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("aavr assertion failed");

// next-cycle implication
`define AAVR_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("aavr assertion failed");

`endif

// ----- sv/aavr_pkg.sv -----
// Types, constants and tables for the axis-angle vertex revolver.
package aavr_pkg;

   localparam int COORD_WIDTH      = 32;
   localparam int MAX_COPIES_DEF   = 64;
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_LEN         = 24;
   localparam int ITER_W           = 5;
   localparam int CNT_W            = 7;
   localparam int AXIS_W           = 16;
   localparam int CS_W             = 18;
   localparam int T_W              = 19;
   localparam int UU_W             = 18;
   localparam int OUTER_W          = 23;
   localparam int SW_W             = 20;
   localparam int M_W              = 24;
   localparam int MUL_A_W          = M_W;
   localparam int MUL_B_W          = (COORD_WIDTH > T_W) ? COORD_WIDTH : T_W;
   localparam int PROD_FULL_W      = MUL_A_W + MUL_B_W;
   localparam int PROD_W           = PROD_FULL_W - 14;
   localparam int ACC_W            = PROD_W + 2;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;
   localparam int OP_W             = 5;

   localparam logic signed [CS_W-1:0] CORDIC_GAIN = 18'sd9949;
   localparam logic signed [T_W-1:0]  ONE_Q14     = 19'sd16384;

   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_AXIS_Z     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_ANGLE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_COPY_COUNT = 3'd4;

   localparam logic [OP_W-1:0] OP_PAIR0  = 5'd0;
   localparam logic [OP_W-1:0] OP_OUTER0 = 5'd6;
   localparam logic [OP_W-1:0] OP_SW0    = 5'd12;
   localparam logic [OP_W-1:0] OP_MV0    = 5'd15;
   localparam logic [OP_W-1:0] OP_LAST   = 5'd23;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] vert_x;
      logic signed [COORD_WIDTH-1:0] vert_y;
      logic signed [COORD_WIDTH-1:0] vert_z;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rot_x;
      logic signed [COORD_WIDTH-1:0] rot_y;
      logic signed [COORD_WIDTH-1:0] rot_z;
      logic [CNT_W-1:0]              copy_index;
      logic                          last_copy;
   } rsp_type;

   typedef struct packed {
      logic              load_vert;
      logic              copy_init;
      logic              cordic_step;
      logic [ITER_W-1:0] iter;
      logic              quad;
      logic              mul_en;
      logic [OP_W-1:0]   mul_op;
      logic              wb_en;
      logic [OP_W-1:0]   wb_op;
      logic              emit;
      logic [CNT_W-1:0]  copy_index;
      logic              last_copy;
   } cmd_type;

   typedef struct packed {
      logic [CNT_W-1:0] copy_count;
   } status_type;

   function automatic logic signed [31:0] atan_turn(input logic [ITER_W-1:0] i);
      logic signed [31:0] r;
      unique case (i)
         5'd0:    r = 32'sh20000000;
         5'd1:    r = 32'sh12E4051D;
         5'd2:    r = 32'sh09FB385B;
         5'd3:    r = 32'sh051111D4;
         5'd4:    r = 32'sh028B0D43;
         5'd5:    r = 32'sh0145D7E1;
         5'd6:    r = 32'sh00A2F61E;
         5'd7:    r = 32'sh00517C55;
         5'd8:    r = 32'sh0028BE53;
         5'd9:    r = 32'sh00145F2F;
         5'd10:   r = 32'sh000A2F98;
         5'd11:   r = 32'sh000517CC;
         5'd12:   r = 32'sh00028BE6;
         5'd13:   r = 32'sh000145F3;
         5'd14:   r = 32'sh0000A2F9;
         5'd15:   r = 32'sh0000517C;
         5'd16:   r = 32'sh000028BE;
         5'd17:   r = 32'sh0000145F;
         5'd18:   r = 32'sh00000A2F;
         5'd19:   r = 32'sh00000517;
         5'd20:   r = 32'sh0000028B;
         5'd21:   r = 32'sh00000145;
         5'd22:   r = 32'sh000000A2;
         5'd23:   r = 32'sh00000051;
         default: r = 32'sh00000000;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_a(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0, 3'd1, 3'd2: r = 2'd0;
         3'd3, 3'd4:       r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] pair_b(input logic [2:0] p);
      logic [1:0] r;
      unique case (p)
         3'd0:       r = 2'd0;
         3'd1, 3'd3: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] mv_row(input logic [3:0] ij);
      logic [1:0] r;
      unique case (ij)
         4'd0, 4'd1, 4'd2: r = 2'd0;
         4'd3, 4'd4, 4'd5: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] mv_col(input logic [3:0] ij);
      logic [1:0] r;
      unique case (ij)
         4'd0, 4'd3, 4'd6: r = 2'd0;
         4'd1, 4'd4, 4'd7: r = 2'd1;
         default:          r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [ACC_W-1:0] v);
      localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'({1'b0, {(COORD_WIDTH-1){1'b1}}});
      localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI - ACC_W'(1);
      logic signed [COORD_WIDTH-1:0] r;
      if (v > LIM_HI) begin
         r = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (v < LIM_LO) begin
         r = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         r = v[COORD_WIDTH-1:0];
      end
      return r;
   endfunction

endpackage

// ----- sv/aavr_ctrl.sv -----
// Sequencer that walks each vertex through its copies, CORDIC and matrix steps.
`include "axis_angle_vertex_revolver_defines.svh"
module aavr_ctrl import aavr_pkg::*; #(
   parameter int MAX_COPIES   = MAX_COPIES_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_INIT   = 3'd1;
   localparam logic [2:0] S_CORDIC = 3'd2;
   localparam logic [2:0] S_QUAD   = 3'd3;
   localparam logic [2:0] S_MUL    = 3'd4;
   localparam logic [2:0] S_DRAIN  = 3'd5;
   localparam logic [2:0] S_EMIT   = 3'd6;

   localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(CORDIC_STEPS - 1);
   localparam logic [CNT_W-1:0]  N_MAX     = CNT_W'(MAX_COPIES);

   logic [2:0]        state_ff, state_in;
   logic [ITER_W-1:0] iter_ff, iter_in;
   logic [OP_W-1:0]   op_ff, op_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  n_ff, n_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              out_free;
   logic              req_fire;
   logic [CNT_W-1:0]  n_clamp;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      priority if (status.copy_count == '0) begin
         n_clamp = CNT_W'(1);
      end else if (status.copy_count > N_MAX) begin
         n_clamp = N_MAX;
      end else begin
         n_clamp = status.copy_count;
      end
   end

   always_comb begin
      state_in     = state_ff;
      iter_in      = iter_ff;
      op_in        = op_ff;
      k_in         = k_ff;
      n_in         = n_ff;
      cmd          = '0;
      cmd.iter       = iter_ff;
      cmd.mul_op     = op_ff;
      cmd.wb_op      = op_ff - OP_W'(1);
      cmd.copy_index = k_ff;
      cmd.last_copy  = (k_ff == n_ff);
      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd.load_vert = 1'b1;
               n_in          = n_clamp;
               k_in          = CNT_W'(1);
               state_in      = S_INIT;
            end
         end
         S_INIT: begin
            cmd.copy_init = 1'b1;
            iter_in       = '0;
            state_in      = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic_step = 1'b1;
            if (iter_ff == ITER_LAST) begin
               state_in = S_QUAD;
            end else begin
               iter_in = iter_ff + ITER_W'(1);
            end
         end
         S_QUAD: begin
            cmd.quad = 1'b1;
            op_in    = OP_PAIR0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.wb_en  = (op_ff != OP_PAIR0);
            if (op_ff == OP_LAST) begin
               state_in = S_DRAIN;
            end else begin
               op_in = op_ff + OP_W'(1);
            end
         end
         S_DRAIN: begin
            cmd.wb_en = 1'b1;
            cmd.wb_op = OP_LAST;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            if (out_free) begin
               cmd.emit = 1'b1;
               if (k_ff == n_ff) begin
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_INIT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         iter_ff      <= '0;
         op_ff        <= '0;
         k_ff         <= CNT_W'(1);
         n_ff         <= CNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         iter_ff      <= iter_in;
         op_ff        <= op_in;
         k_ff         <= k_in;
         n_ff         <= n_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `AAVR_ASSERT_NXT(a_req_starts_copy, clock, reset, req_fire, state_ff == S_INIT)
   `AAVR_ASSERT_NXT(a_emit_sets_valid, clock, reset, cmd.emit, rsp_valid_ff)
   `AAVR_ASSERT_IMP(a_copy_in_range, clock, reset, state_ff != S_IDLE, k_ff <= n_ff && k_ff != '0)
   `AAVR_ASSERT_NXT(a_cordic_to_quad, clock, reset, state_ff == S_CORDIC && iter_ff == ITER_LAST, state_ff == S_QUAD)

endmodule

// ----- sv/aavr_datapath.sv -----
// Datapath: settings, CORDIC sine/cosine, shared multiplier and coordinate sums.
module aavr_datapath import aavr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  req_type               req_data,
   input  cmd_type               cmd,
   output status_type            status,
   output rsp_type               rsp_data
);

   logic signed [AXIS_W-1:0]      axis_ff [3];
   logic [15:0]                   step_ff;
   logic [CNT_W-1:0]              count_ff;

   logic signed [COORD_WIDTH-1:0] v_ff [3];
   logic [15:0]                   ang_ff;
   logic [1:0]                    q_ff;
   logic signed [CS_W-1:0]        cx_ff, cy_ff;
   logic signed [31:0]            cz_ff;
   logic signed [CS_W-1:0]        c_ff, s_ff;
   logic signed [T_W-1:0]         t_ff;
   logic signed [UU_W-1:0]        uu_ff [6];
   logic signed [OUTER_W-1:0]     o_ff [6];
   logic signed [SW_W-1:0]        sw_ff [3];
   logic signed [PROD_W-1:0]      prod_ff;
   logic signed [ACC_W-1:0]       acc_ff [3];
   rsp_type                       rsp_ff;

   logic [15:0]                   ang_in;
   logic [15:0]                   ang_q;
   logic [1:0]                    q_in;
   logic [15:0]                   resid;
   logic signed [CS_W-1:0]        sh_x, sh_y, nx, ny;
   logic signed [31:0]            atan, nz;
   logic signed [CS_W-1:0]        c_in, s_in;
   logic signed [MUL_A_W-1:0]     op_a;
   logic signed [MUL_B_W-1:0]     op_b;
   logic signed [PROD_FULL_W-1:0] prod_full;
   logic [OP_W-1:0]               mop_rel, wop_rel;
   logic [3:0]                    mij, wij;
   logic [1:0]                    mcol, wrow, wcol;
   logic signed [M_W-1:0]         m_val;
   logic signed [M_W-1:0]         c_ext;

   assign status.copy_count = count_ff;
   assign rsp_data          = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_ff[0] <= 16'sd16384;
         axis_ff[1] <= '0;
         axis_ff[2] <= '0;
         step_ff    <= '0;
         count_ff   <= CNT_W'(1);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_AXIS_X:     axis_ff[0] <= csr_wdata;
            CSR_AXIS_Y:     axis_ff[1] <= csr_wdata;
            CSR_AXIS_Z:     axis_ff[2] <= csr_wdata;
            CSR_STEP_ANGLE: step_ff    <= csr_wdata;
            CSR_COPY_COUNT: count_ff   <= csr_wdata[CNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // angle of the next copy, quadrant split and residual
   assign ang_in = ang_ff + step_ff;
   assign ang_q  = ang_in + 16'h2000;
   assign q_in   = ang_q[15:14];
   assign resid  = ang_in - {q_in, 14'd0};

   assign sh_x = cx_ff >>> cmd.iter;
   assign sh_y = cy_ff >>> cmd.iter;
   assign atan = atan_turn(cmd.iter);

   always_comb begin
      if (!cz_ff[31]) begin
         nx = cx_ff - sh_y;
         ny = cy_ff + sh_x;
         nz = cz_ff - atan;
      end else begin
         nx = cx_ff + sh_y;
         ny = cy_ff - sh_x;
         nz = cz_ff + atan;
      end
   end

   always_comb begin
      unique case (q_ff)
         2'd0: begin c_in = cx_ff;  s_in = cy_ff;  end
         2'd1: begin c_in = -cy_ff; s_in = cx_ff;  end
         2'd2: begin c_in = -cx_ff; s_in = -cy_ff; end
         default: begin c_in = cy_ff; s_in = -cx_ff; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load_vert) begin
         v_ff[0] <= req_data.vert_x;
         v_ff[1] <= req_data.vert_y;
         v_ff[2] <= req_data.vert_z;
         ang_ff  <= '0;
      end
      if (cmd.copy_init) begin
         ang_ff <= ang_in;
         q_ff   <= q_in;
         cx_ff  <= CORDIC_GAIN;
         cy_ff  <= '0;
         cz_ff  <= {resid, 16'd0};
      end
      if (cmd.cordic_step) begin
         cx_ff <= nx;
         cy_ff <= ny;
         cz_ff <= nz;
      end
      if (cmd.quad) begin
         c_ff <= c_in;
         s_ff <= s_in;
         t_ff <= ONE_Q14 - T_W'(c_in);
      end
   end

   // matrix entry for the current multiply-by-vertex step
   assign mop_rel = cmd.mul_op - OP_MV0;
   assign mij     = mop_rel[3:0];
   assign mcol    = mv_col(mij);
   assign c_ext   = M_W'(c_ff);

   always_comb begin
      unique case (mij)
         4'd0:    m_val = c_ext + M_W'(o_ff[0]);
         4'd1:    m_val = M_W'(o_ff[1]) - M_W'(sw_ff[2]);
         4'd2:    m_val = M_W'(o_ff[2]) + M_W'(sw_ff[1]);
         4'd3:    m_val = M_W'(o_ff[1]) + M_W'(sw_ff[2]);
         4'd4:    m_val = c_ext + M_W'(o_ff[3]);
         4'd5:    m_val = M_W'(o_ff[4]) - M_W'(sw_ff[0]);
         4'd6:    m_val = M_W'(o_ff[2]) - M_W'(sw_ff[1]);
         4'd7:    m_val = M_W'(o_ff[4]) + M_W'(sw_ff[0]);
         default: m_val = c_ext + M_W'(o_ff[5]);
      endcase
   end

   always_comb begin
      logic [OP_W-1:0] rel;
      rel = '0;
      if (cmd.mul_op < OP_OUTER0) begin
         op_a = MUL_A_W'(axis_ff[pair_a(cmd.mul_op[2:0])]);
         op_b = MUL_B_W'(axis_ff[pair_b(cmd.mul_op[2:0])]);
      end else if (cmd.mul_op < OP_SW0) begin
         rel  = cmd.mul_op - OP_OUTER0;
         op_a = MUL_A_W'(uu_ff[rel[2:0]]);
         op_b = MUL_B_W'(t_ff);
      end else if (cmd.mul_op < OP_MV0) begin
         rel  = cmd.mul_op - OP_SW0;
         op_a = MUL_A_W'(axis_ff[rel[1:0]]);
         op_b = MUL_B_W'(s_ff);
      end else begin
         op_a = m_val;
         op_b = MUL_B_W'(v_ff[mcol]);
      end
   end

   assign prod_full = PROD_FULL_W'(op_a) * PROD_FULL_W'(op_b);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= prod_full[PROD_FULL_W-1:14];
      end
   end

   assign wop_rel = cmd.wb_op - OP_MV0;
   assign wij     = wop_rel[3:0];
   assign wrow    = mv_row(wij);
   assign wcol    = mv_col(wij);

   always_ff @(posedge clock) begin
      logic [OP_W-1:0] rel;
      rel = '0;
      if (cmd.wb_en) begin
         if (cmd.wb_op < OP_OUTER0) begin
            uu_ff[cmd.wb_op[2:0]] <= prod_ff[UU_W-1:0];
         end else if (cmd.wb_op < OP_SW0) begin
            rel = cmd.wb_op - OP_OUTER0;
            o_ff[rel[2:0]] <= prod_ff[OUTER_W-1:0];
         end else if (cmd.wb_op < OP_MV0) begin
            rel = cmd.wb_op - OP_SW0;
            sw_ff[rel[1:0]] <= prod_ff[SW_W-1:0];
         end else if (wcol == 2'd0) begin
            acc_ff[wrow] <= ACC_W'(prod_ff);
         end else begin
            acc_ff[wrow] <= acc_ff[wrow] + ACC_W'(prod_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_ff.rot_x      <= sat_coord(acc_ff[0]);
         rsp_ff.rot_y      <= sat_coord(acc_ff[1]);
         rsp_ff.rot_z      <= sat_coord(acc_ff[2]);
         rsp_ff.copy_index <= cmd.copy_index;
         rsp_ff.last_copy  <= cmd.last_copy;
      end
   end

endmodule

// ----- sv/axis_angle_vertex_revolver.sv -----
// Top level of the axis-angle vertex revolver.
//
//   channel  direction  handshake               payload
//   req      in         req_valid / req_ready   req_data  (vert_x, vert_y, vert_z)
//   rsp      out        rsp_valid / rsp_ready   rsp_data  (rot_x..z, copy_index, last_copy)
//   csr      in         csr_wr_en               csr_index, csr_wdata
//
// Each copy runs CORDIC_STEPS CORDIC iterations, one per cycle, then 24 passes
// through the single shared multiplier, drain and output load. A vertex runs its
// copies in turn; a stalled rsp holds the sequencer at the output load. Reset is
// synchronous; no clearing pass is needed.
module axis_angle_vertex_revolver import aavr_pkg::*; #(
   parameter int MAX_COPIES   = MAX_COPIES_DEF,
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cmd_type    cmd;
   status_type status;

   aavr_ctrl #(
      .MAX_COPIES   (MAX_COPIES),
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   aavr_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_data  (rsp_data)
   );

endmodule
